FILE: hw/rtl/tfp_pkg.sv
package tfp_pkg;

  localparam int unsigned FrameLen = 16;
  localparam int unsigned PosW = $clog2(FrameLen);

  localparam logic [7:0] Hdr0 = 8'd87;
  localparam logic [7:0] Hdr1 = 8'd0;
  localparam logic [7:0] Hdr2 = 8'd255;

  localparam logic [PosW-1:0] PosHdr0  = 4'd0;
  localparam logic [PosW-1:0] PosHdr1  = 4'd1;
  localparam logic [PosW-1:0] PosHdr2  = 4'd2;
  localparam logic [PosW-1:0] PosId    = 4'd3;
  localparam logic [PosW-1:0] PosTime0 = 4'd4;
  localparam logic [PosW-1:0] PosTime1 = 4'd5;
  localparam logic [PosW-1:0] PosTime2 = 4'd6;
  localparam logic [PosW-1:0] PosTime3 = 4'd7;
  localparam logic [PosW-1:0] PosDist0 = 4'd8;
  localparam logic [PosW-1:0] PosDist1 = 4'd9;
  localparam logic [PosW-1:0] PosDist2 = 4'd10;
  localparam logic [PosW-1:0] PosStat  = 4'd11;
  localparam logic [PosW-1:0] PosSig0  = 4'd12;
  localparam logic [PosW-1:0] PosSig1  = 4'd13;
  localparam logic [PosW-1:0] PosCsum  = 4'd15;

  typedef enum logic [1:0] {
    OUTCOME_OK    = 2'd0,
    OUTCOME_RANGE = 2'd1,
    OUTCOME_BAD   = 2'd2
  } outcome_t;

endpackage

FILE: hw/rtl/tof_frame_parser.sv
// result: registered, it appears on the out_ port in the cycle after the checksum byte is accepted
// throughput: one byte per cycle; a byte is refused only while a finished result
// sits in the output register and out_ready is low
// reset (rst_n, synchronous, active low): framing restarts at byte 0, output empty
module tof_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_sensor_id,
  output logic [31:0] out_sensor_time,
  output logic [23:0] out_distance_value,
  output logic [7:0]  out_sensor_status,
  output logic [15:0] out_signal_strength
);
  import tfp_pkg::*;

  logic [PosW-1:0] byte_position_r, byte_position_nxt;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic            header_good_r, header_good_nxt;
  logic [7:0]      id_hold_r, id_hold_nxt;
  logic [31:0]     time_hold_r, time_hold_nxt;
  logic [23:0]     distance_hold_r, distance_hold_nxt;
  logic [7:0]      status_hold_r, status_hold_nxt;
  logic [15:0]     signal_hold_r, signal_hold_nxt;

  logic            out_valid_r, out_valid_nxt;
  outcome_t        outcome_r, outcome_nxt;
  logic [7:0]      sensor_id_r, sensor_id_nxt;
  logic [31:0]     sensor_time_r, sensor_time_nxt;
  logic [23:0]     distance_r, distance_nxt;
  logic [7:0]      status_r, status_nxt;
  logic [15:0]     signal_r, signal_nxt;

  logic            in_fire;
  logic [PosW-1:0] pos;
  logic            frame_good;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign pos      = in_frame_start ? PosHdr0 : byte_position_r;
  assign frame_good = header_good_r && (running_sum_r == in_rx_byte);

  always_comb begin
    byte_position_nxt = byte_position_r;
    running_sum_nxt   = running_sum_r;
    header_good_nxt   = header_good_r;
    id_hold_nxt       = id_hold_r;
    time_hold_nxt     = time_hold_r;
    distance_hold_nxt = distance_hold_r;
    status_hold_nxt   = status_hold_r;
    signal_hold_nxt   = signal_hold_r;

    out_valid_nxt   = out_valid_r && !out_ready;
    outcome_nxt     = outcome_r;
    sensor_id_nxt   = sensor_id_r;
    sensor_time_nxt = sensor_time_r;
    distance_nxt    = distance_r;
    status_nxt      = status_r;
    signal_nxt      = signal_r;

    if (in_fire) begin
      byte_position_nxt = pos + 1'b1;

      // field capture by frame position
      case (pos)
        PosHdr0:  header_good_nxt = (in_rx_byte == Hdr0);
        PosHdr1:  header_good_nxt = header_good_r && (in_rx_byte == Hdr1);
        PosHdr2:  header_good_nxt = header_good_r && (in_rx_byte == Hdr2);
        PosId:    id_hold_nxt = in_rx_byte;
        PosTime0: time_hold_nxt[7:0]   = in_rx_byte;
        PosTime1: time_hold_nxt[15:8]  = in_rx_byte;
        PosTime2: time_hold_nxt[23:16] = in_rx_byte;
        PosTime3: time_hold_nxt[31:24] = in_rx_byte;
        PosDist0: distance_hold_nxt[7:0]   = in_rx_byte;
        PosDist1: distance_hold_nxt[15:8]  = in_rx_byte;
        PosDist2: distance_hold_nxt[23:16] = in_rx_byte;
        PosStat:  status_hold_nxt = in_rx_byte;
        PosSig0:  signal_hold_nxt[7:0]  = in_rx_byte;
        PosSig1:  signal_hold_nxt[15:8] = in_rx_byte;
        default: ;
      endcase

      if (pos == PosCsum) begin
        out_valid_nxt   = 1'b1;
        outcome_nxt     = OUTCOME_OK;
        sensor_id_nxt   = '0;
        sensor_time_nxt = '0;
        distance_nxt    = '0;
        status_nxt      = '0;
        signal_nxt      = '0;
        if (!frame_good) begin
          outcome_nxt = OUTCOME_BAD;
        end else if (signal_hold_r == '0) begin
          outcome_nxt = OUTCOME_RANGE;
        end else begin
          sensor_id_nxt   = id_hold_r;
          sensor_time_nxt = time_hold_r;
          distance_nxt    = distance_hold_r;
          status_nxt      = status_hold_r;
          signal_nxt      = signal_hold_r;
        end
      end else if (pos == PosHdr0) begin
        running_sum_nxt = in_rx_byte;
      end else begin
        running_sum_nxt = running_sum_r + in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r <= '0;
      running_sum_r   <= '0;
      header_good_r   <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      byte_position_r <= byte_position_nxt;
      running_sum_r   <= running_sum_nxt;
      header_good_r   <= header_good_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers, always written before use within a frame
  always_ff @(posedge clk) begin
    id_hold_r       <= id_hold_nxt;
    time_hold_r     <= time_hold_nxt;
    distance_hold_r <= distance_hold_nxt;
    status_hold_r   <= status_hold_nxt;
    signal_hold_r   <= signal_hold_nxt;
    outcome_r       <= outcome_nxt;
    sensor_id_r     <= sensor_id_nxt;
    sensor_time_r   <= sensor_time_nxt;
    distance_r      <= distance_nxt;
    status_r        <= status_nxt;
    signal_r        <= signal_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = outcome_r;
  assign out_sensor_id       = sensor_id_r;
  assign out_sensor_time     = sensor_time_r;
  assign out_distance_value  = distance_r;
  assign out_sensor_status   = status_r;
  assign out_signal_strength = signal_r;

endmodule
